// ===== src/cstt_pkg.sv =====
// types and constants shared by the call stack trace tracker modules
package cstt_pkg;

    // one retired-instruction record
    typedef struct packed {
        logic [63:0] cycle;
        logic [39:0] iaddr;
        logic        resolved;
        logic [15:0] func_id;
        logic        call_site;
        logic        fn_entry;
        logic        in_asm_seq;
    } rec_t;

    // one region event
    typedef struct packed {
        logic [1:0]  event_kind;
        logic [15:0] region_func;
        logic        region_user;
        logic [63:0] open_cyc;
        logic [63:0] close_cyc;
        logic [5:0]  depth;
        logic [39:0] warn_addr;
        logic        last;
    } evt_t;

    // classified command handed from front to back
    typedef struct packed {
        logic [63:0] cycle;
        logic [39:0] iaddr;
        logic        user;
        logic [15:0] func;
        logic        asm_flag;
        logic        unwind;
    } cmd_t;

    // one shadow stack entry
    typedef struct packed {
        logic [15:0] func;
        logic        user;
        logic        asm_flag;
        logic [63:0] open_cyc;
        logic [63:0] close_cyc;
    } entry_t;

    localparam logic [1:0] EV_ENTER    = 2'd0;
    localparam logic [1:0] EV_EXIT     = 2'd1;
    localparam logic [1:0] EV_ZEROED   = 2'd2;
    localparam logic [1:0] EV_OVERFLOW = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_POP1,
        S_POP2,
        S_PUSH,
        S_WARN
    } state_t;

    typedef enum logic [1:0] {
        PM_FULL,
        PM_USER,
        PM_UNWIND,
        PM_SWAP
    } pop_mode_t;

endpackage

// ===== src/call_stack_trace_tracker_unit.sv =====
// call stack trace tracker top level
// a record passes the front end and the command queue; S_IDLE pops it into the command
// register and S_EVAL classifies it; a record that only extends the top region ends there;
//   each popped region adds S_POP1 and S_POP2 (at most one memory read), plus S_EVAL when
//   leaving userspace, a push or warning adds its state, and output stalls hold them
// reset: asynchronous active low; stack empties at once, no clearing pass
module call_stack_trace_tracker_unit #(
    parameter int STACK_DEPTH = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            rec_valid,
    output logic            rec_stall,
    input  cstt_pkg::rec_t  rec,
    output logic            evt_valid,
    input  logic            evt_stall,
    output cstt_pkg::evt_t  evt
);

    logic           q_full, q_empty, q_push, q_pop;
    cstt_pkg::cmd_t q_data, q_head;

    cstt_front u_front (
        .rec_valid (rec_valid),
        .rec_stall (rec_stall),
        .rec       (rec),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_data)
    );

    cstt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_data),
        .pop       (q_pop),
        .full      (q_full),
        .empty     (q_empty),
        .head      (q_head)
    );

    cstt_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .evt       (evt)
    );

endmodule

// ===== src/cstt_front.sv =====
// front end: accepts records and classifies them into commands
module cstt_front (
    input  logic            rec_valid,
    output logic            rec_stall,
    input  cstt_pkg::rec_t  rec,
    input  logic            q_full,
    output logic            q_push,
    output cstt_pkg::cmd_t  q_data
);

    // accept whenever the queue has room
    assign rec_stall = q_full;
    assign q_push    = rec_valid && !q_full;

    // classify the record
    always_comb
    begin
        q_data.cycle     = rec.cycle;
        q_data.iaddr     = rec.iaddr;
        q_data.user      = !rec.resolved;
        q_data.func      = rec.resolved ? rec.func_id : 16'd0;
        q_data.asm_flag  = rec.resolved && rec.in_asm_seq;
        q_data.unwind    = rec.call_site || !rec.fn_entry;
    end

endmodule

// ===== src/cstt_queue.sv =====
// two-entry command queue between front and back
module cstt_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  cstt_pkg::cmd_t  push_data,
    input  logic            pop,
    output logic            full,
    output logic            empty,
    output cstt_pkg::cmd_t  head
);

    cstt_pkg::cmd_t q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full  = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign head  = q_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // payload storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== src/cstt_back.sv =====
// back end: shadow stack engine and event output register
module cstt_back #(
    parameter int STACK_DEPTH = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_empty,
    input  cstt_pkg::cmd_t  q_head,
    output logic            q_pop,
    output logic            evt_valid,
    input  logic            evt_stall,
    output cstt_pkg::evt_t  evt
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    cstt_pkg::state_t    state_reg, state_next;
    cstt_pkg::pop_mode_t mode_reg, mode_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       lvl_reg, lvl_next;
    cstt_pkg::entry_t    top_reg, top_next;
    cstt_pkg::entry_t    exit_reg, exit_next;
    cstt_pkg::cmd_t      cmd_reg, cmd_next;
    cstt_pkg::evt_t      out_reg, out_next;
    logic                out_valid_reg, out_valid_next;

    // stack memory below the cached top entry
    cstt_pkg::entry_t    mem [STACK_DEPTH];
    cstt_pkg::entry_t    rd_data_reg;
    logic                rd_en, wr_en;
    logic [AW-1:0]       rd_addr, wr_addr;
    cstt_pkg::entry_t    wr_data;

    logic                out_free;
    logic                have_new, matched;
    cstt_pkg::entry_t    new_top, push_ent;
    cstt_pkg::evt_t      ev;

    assign out_free  = !out_valid_reg || !evt_stall;
    assign evt_valid = out_valid_reg;
    assign evt       = out_reg;

    // entry that a push would create
    always_comb
    begin
        push_ent.func      = cmd_reg.func;
        push_ent.user      = cmd_reg.user;
        push_ent.asm_flag  = cmd_reg.asm_flag;
        push_ent.open_cyc  = cmd_reg.cycle;
        push_ent.close_cyc = cmd_reg.cycle;
    end

    // entry revealed by a pop
    always_comb
    begin
        have_new = (count_reg != '0);
        matched  = have_new && !rd_data_reg.user && (rd_data_reg.func == cmd_reg.func);
        new_top  = rd_data_reg;
        if (mode_reg == cstt_pkg::PM_FULL || mode_reg == cstt_pkg::PM_UNWIND)
        begin
            new_top.close_cyc = cmd_reg.cycle;
        end
    end

    // next state and outputs
    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        count_next     = count_reg;
        lvl_next       = lvl_reg;
        top_next       = top_reg;
        exit_next      = exit_reg;
        cmd_next       = cmd_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && evt_stall;
        q_pop          = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = AW'(count_reg - CW'(2));
        wr_en          = 1'b0;
        wr_addr        = AW'(count_reg - CW'(1));
        wr_data        = top_reg;
        ev             = '0;

        case (state_reg)
            cstt_pkg::S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    cmd_next   = q_head;
                    state_next = cstt_pkg::S_EVAL;
                end
            end

            cstt_pkg::S_EVAL:
            begin
                if (cmd_reg.user)
                begin
                    // unresolved: extend a lone userspace region, else collapse the stack and open one
                    if (count_reg == CW'(1) && top_reg.user)
                    begin
                        top_next.close_cyc = cmd_reg.cycle;
                        state_next         = cstt_pkg::S_IDLE;
                    end
                    else if (count_reg != '0)
                    begin
                        mode_next  = cstt_pkg::PM_FULL;
                        state_next = cstt_pkg::S_POP1;
                    end
                    else
                    begin
                        state_next = cstt_pkg::S_PUSH;
                    end
                end
                else if (count_reg != '0 && top_reg.user)
                begin
                    mode_next  = cstt_pkg::PM_USER;
                    state_next = cstt_pkg::S_POP1;
                end
                else if (count_reg != '0 && top_reg.func == cmd_reg.func)
                begin
                    top_next.close_cyc = cmd_reg.cycle;
                    state_next         = cstt_pkg::S_IDLE;
                end
                else if (count_reg != '0 && cmd_reg.asm_flag && top_reg.asm_flag)
                begin
                    mode_next  = cstt_pkg::PM_SWAP;
                    state_next = cstt_pkg::S_POP1;
                end
                else if (count_reg != '0 && cmd_reg.unwind)
                begin
                    lvl_next   = count_reg;
                    mode_next  = cstt_pkg::PM_UNWIND;
                    state_next = cstt_pkg::S_POP1;
                end
                else
                begin
                    state_next = cstt_pkg::S_PUSH;
                end
            end

            cstt_pkg::S_POP1:
            begin
                // take the top aside and fetch the entry below it
                exit_next  = top_reg;
                count_next = count_reg - CW'(1);
                rd_en      = (count_reg >= CW'(2));
                state_next = cstt_pkg::S_POP2;
            end

            cstt_pkg::S_POP2:
            begin
                if (out_free)
                begin
                    ev.event_kind  = cstt_pkg::EV_EXIT;
                    ev.region_func = exit_reg.func;
                    ev.region_user = exit_reg.user;
                    ev.open_cyc    = exit_reg.open_cyc;
                    ev.close_cyc   = exit_reg.close_cyc;
                    ev.depth       = 6'(count_reg + CW'(1));
                    ev.last        = (mode_reg == cstt_pkg::PM_USER ||
                                      mode_reg == cstt_pkg::PM_UNWIND) && matched;
                    out_next       = ev;
                    out_valid_next = 1'b1;
                    if (have_new)
                    begin
                        top_next = new_top;
                    end
                    case (mode_reg)
                        cstt_pkg::PM_FULL:
                            state_next = have_new ? cstt_pkg::S_POP1 : cstt_pkg::S_PUSH;
                        cstt_pkg::PM_USER:
                            state_next = cstt_pkg::S_EVAL;
                        cstt_pkg::PM_UNWIND:
                            state_next = matched ? cstt_pkg::S_IDLE
                                       : (have_new ? cstt_pkg::S_POP1 : cstt_pkg::S_WARN);
                        default:
                            state_next = cstt_pkg::S_PUSH;
                    endcase
                end
            end

            cstt_pkg::S_PUSH:
            begin
                if (out_free)
                begin
                    ev.region_func = cmd_reg.func;
                    ev.open_cyc    = cmd_reg.cycle;
                    ev.close_cyc   = cmd_reg.cycle;
                    ev.last        = 1'b1;
                    if (count_reg == CW'(STACK_DEPTH))
                    begin
                        // full stack: refuse the push
                        ev.event_kind = cstt_pkg::EV_OVERFLOW;
                        ev.depth      = 6'(STACK_DEPTH);
                    end
                    else
                    begin
                        ev.event_kind  = cstt_pkg::EV_ENTER;
                        ev.region_user = cmd_reg.user;
                        ev.depth       = 6'(count_reg + CW'(1));
                        wr_en          = (count_reg != '0);
                        top_next       = push_ent;
                        count_next     = count_reg + CW'(1);
                    end
                    out_next       = ev;
                    out_valid_next = 1'b1;
                    state_next     = cstt_pkg::S_IDLE;
                end
            end

            cstt_pkg::S_WARN:
            begin
                if (out_free)
                begin
                    ev.event_kind  = cstt_pkg::EV_ZEROED;
                    ev.region_func = cmd_reg.func;
                    ev.open_cyc    = cmd_reg.cycle;
                    ev.close_cyc   = cmd_reg.cycle;
                    ev.depth       = 6'(lvl_reg);
                    ev.warn_addr   = cmd_reg.iaddr;
                    ev.last        = 1'b1;
                    out_next       = ev;
                    out_valid_next = 1'b1;
                    state_next     = cstt_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = cstt_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cstt_pkg::S_IDLE;
            mode_reg      <= cstt_pkg::PM_FULL;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        lvl_reg  <= lvl_next;
        top_reg  <= top_next;
        exit_reg <= exit_next;
        cmd_reg  <= cmd_next;
        out_reg  <= out_next;
    end

    // stack memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // stack never grows past its depth
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(STACK_DEPTH))
        else $error("stack count above depth");

    // a spill only happens onto a non-empty, non-full stack
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (count_reg != '0 && count_reg < CW'(STACK_DEPTH)))
        else $error("spill with bad count");

    // a pop always lowers the count by one
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == cstt_pkg::S_POP1 |=> count_reg == $past(count_reg) - CW'(1))
        else $error("pop did not decrement count");

    // a beat still waiting while idle is the final one of its record
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cstt_pkg::S_IDLE && out_valid_reg) |-> out_reg.last)
        else $error("non-final beat pending at idle");

endmodule

// ===== verif/cstt_checker.sv =====
// event checker for the call stack trace tracker: shadow stack prediction and compare
`timescale 1ns / 100ps
module cstt_checker #(
    parameter int STACK_DEPTH = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            rec_valid,
    input  logic            rec_stall,
    input  cstt_pkg::rec_t  rec,
    input  logic            evt_valid,
    input  logic            evt_stall,
    input  cstt_pkg::evt_t  evt,
    output int              fail_count,
    output int              pending,
    output int              evt_seen
);

    // shadow copy of the region stack
    logic [15:0] sh_func  [STACK_DEPTH];
    logic        sh_user  [STACK_DEPTH];
    logic        sh_asm   [STACK_DEPTH];
    logic [63:0] sh_start [STACK_DEPTH];
    logic [63:0] sh_end   [STACK_DEPTH];
    int          sh_count;

    cstt_pkg::evt_t expected_events[$];
    cstt_pkg::evt_t step_events[$];

    initial
    begin
        fail_count = 0;
        evt_seen   = 0;
        pending    = 0;
        sh_count   = 0;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    function automatic void add_event(logic [1:0] kind, logic [15:0] func, logic user,
                                      logic [63:0] st, logic [63:0] en, int dep,
                                      logic [39:0] waddr);
        cstt_pkg::evt_t e;
        e.event_kind  = kind;
        e.region_func = func;
        e.region_user = user;
        e.open_cyc    = st;
        e.close_cyc   = en;
        e.depth       = dep[5:0];
        e.warn_addr   = waddr;
        e.last        = 1'b0;
        step_events.insert(step_events.size(), e);
    endfunction

    function automatic void close_top();
        int t;
        if (sh_count == 0)
            return;
        t = sh_count - 1;
        add_event(cstt_pkg::EV_EXIT, sh_func[t], sh_user[t], sh_start[t], sh_end[t],
                  t + 1, '0);
        sh_count = t;
    endfunction

    function automatic void open_region(logic [15:0] func, logic user, logic asmf,
                                        logic [63:0] cyc);
        int t;
        t = sh_count;
        if (t >= STACK_DEPTH)
        begin
            add_event(cstt_pkg::EV_OVERFLOW, func, 1'b0, cyc, cyc, STACK_DEPTH, '0);
            return;
        end
        sh_func[t]  = func;
        sh_user[t]  = user;
        sh_asm[t]   = asmf;
        sh_start[t] = cyc;
        sh_end[t]   = cyc;
        sh_count    = t + 1;
        add_event(cstt_pkg::EV_ENTER, func, user, cyc, cyc, t + 1, '0);
    endfunction

    // update the shadow stack for one record and queue its events
    function automatic void track_record(cstt_pkg::rec_t r);
        int lvl;
        step_events.delete();
        if (!r.resolved)
        begin
            if (sh_count == 1 && sh_user[0])
                sh_end[0] = r.cycle;
            else
            begin
                while (sh_count > 0)
                begin
                    close_top();
                    if (sh_count > 0)
                        sh_end[sh_count - 1] = r.cycle;
                end
                open_region(16'd0, 1'b1, 1'b0, r.cycle);
            end
        end
        else
        begin
            if (sh_count > 0 && sh_user[sh_count - 1])
                close_top();
            if (sh_count > 0 && !sh_user[sh_count - 1] && sh_func[sh_count - 1] == r.func_id)
                sh_end[sh_count - 1] = r.cycle;
            else if (sh_count > 0 && r.in_asm_seq && sh_asm[sh_count - 1])
            begin
                close_top();
                open_region(r.func_id, 1'b0, r.in_asm_seq, r.cycle);
            end
            else if (sh_count > 0 && (r.call_site || !r.fn_entry))
            begin
                lvl = sh_count;
                while (sh_count > 0 && (sh_user[sh_count - 1] ||
                       sh_func[sh_count - 1] != r.func_id))
                begin
                    close_top();
                    if (sh_count > 0)
                        sh_end[sh_count - 1] = r.cycle;
                end
                if (sh_count == 0)
                    add_event(cstt_pkg::EV_ZEROED, r.func_id, 1'b0, r.cycle, r.cycle, lvl,
                              r.iaddr);
            end
            else
                open_region(r.func_id, 1'b0, r.in_asm_seq, r.cycle);
        end
        if (step_events.size() > 0)
            step_events[step_events.size() - 1].last = 1'b1;
        expected_events = {expected_events, step_events};
    endfunction

    // watch both channels
    always @(posedge clk)
    begin
        cstt_pkg::evt_t want;
        if (rst_n)
        begin
            if (rec_valid && !rec_stall)
                track_record(rec);
            if (evt_valid && !evt_stall)
            begin
                evt_seen++;
                if (expected_events.size() == 0)
                    report_mismatch("unexpected beat", 64'(evt.event_kind), '0);
                else
                begin
                    want = expected_events.pop_front();
                    if (evt.event_kind !== want.event_kind)
                        report_mismatch("event_kind", 64'(evt.event_kind),
                                        64'(want.event_kind));
                    if (evt.region_func !== want.region_func)
                        report_mismatch("region_func", 64'(evt.region_func),
                                        64'(want.region_func));
                    if (evt.region_user !== want.region_user)
                        report_mismatch("region_user", 64'(evt.region_user),
                                        64'(want.region_user));
                    if (evt.open_cyc !== want.open_cyc)
                        report_mismatch("open_cyc", evt.open_cyc, want.open_cyc);
                    if (evt.close_cyc !== want.close_cyc)
                        report_mismatch("close_cyc", evt.close_cyc, want.close_cyc);
                    if (evt.depth !== want.depth)
                        report_mismatch("depth", 64'(evt.depth), 64'(want.depth));
                    if (evt.warn_addr !== want.warn_addr)
                        report_mismatch("warn_addr", 64'(evt.warn_addr),
                                        64'(want.warn_addr));
                    if (evt.last !== want.last)
                        report_mismatch("last", 64'(evt.last), 64'(want.last));
                end
            end
            pending = expected_events.size();
        end
    end

endmodule

// ===== verif/testbench.sv =====
// stimulus and verdict for the call stack trace tracker
`timescale 1ns / 100ps
module testbench;

    localparam int DEPTH      = 32;
    localparam int IDLE_LIMIT = 20000;

    logic clk;
    logic rst_n;
    logic rec_valid;
    logic rec_stall;
    cstt_pkg::rec_t rec;
    logic evt_valid;
    logic evt_stall;
    cstt_pkg::evt_t evt;
    int   fail_count;
    int   pending;
    int   evt_seen;
    int   rec_sent;
    int   idle_cycles = 0;
    bit   quiet_tail;
    logic [63:0] cyc_now;
    logic [15:0] call_chain[$];

    call_stack_trace_tracker_unit #(.STACK_DEPTH(DEPTH)) uut (
        .clk(clk), .rst_n(rst_n),
        .rec_valid(rec_valid), .rec_stall(rec_stall), .rec(rec),
        .evt_valid(evt_valid), .evt_stall(evt_stall), .evt(evt)
    );

    cstt_checker #(.STACK_DEPTH(DEPTH)) checker_i (
        .clk(clk), .rst_n(rst_n),
        .rec_valid(rec_valid), .rec_stall(rec_stall), .rec(rec),
        .evt_valid(evt_valid), .evt_stall(evt_stall), .evt(evt),
        .fail_count(fail_count), .pending(pending), .evt_seen(evt_seen)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // receiver stall bursts, plus one long hold-off
    initial
    begin
        int n;
        bit hold_done;
        evt_stall = 1'b0;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!hold_done && rec_sent >= 67)
            begin
                evt_stall <= 1'b1;
                repeat (300) @(posedge clk);
                hold_done = 1'b1;
            end
            else if (!quiet_tail && $urandom_range(0, 2) == 0)
            begin
                n = $urandom_range(1, 15);
                evt_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            else
            begin
                evt_stall <= 1'b0;
                @(posedge clk);
            end
        end
    end

    // watchdog on accepted beats
    always @(posedge clk)
    begin
        if ((rec_valid && !rec_stall) || (evt_valid && !evt_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog expired");
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // drive one record and wait for acceptance, with an optional gap first
    task automatic send_record(logic [63:0] cyc, logic [39:0] addr, logic res,
                               logic [15:0] fid, logic call, logic entry, logic asmf);
        cstt_pkg::rec_t r;
        int gap;
        if (!quiet_tail && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 15);
            rec_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        r.cycle = cyc;
        r.iaddr = addr;
        r.resolved = res;
        r.func_id = fid;
        r.call_site = call;
        r.fn_entry = entry;
        r.in_asm_seq = asmf;
        rec <= r;
        rec_valid <= 1'b1;
        do
            @(posedge clk);
        while (rec_stall);
        rec_sent++;
    endtask

    task automatic next_cycle(output logic [63:0] c);
        cyc_now = cyc_now + 64'($urandom_range(1, 40));
        c = cyc_now;
    endtask

    task automatic random_record();
        logic [63:0] c;
        logic [39:0] a;
        logic [15:0] f;
        int pick;
        next_cycle(c);
        a = {8'($urandom), $urandom};
        pick = $urandom_range(0, 99);
        if (pick < 8)
            send_record(c, a, 1'b0, 16'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
        else if (pick < 40 || call_chain.size() == 0)
        begin
            // call into a new function
            f = 16'($urandom_range(1, 40));
            call_chain = {call_chain, f};
            send_record(c, a, 1'b1, f, 1'b0, 1'b1, 1'($urandom_range(0, 5) == 0));
        end
        else if (pick < 65)
            send_record(c, a, 1'b1, call_chain[call_chain.size() - 1], 1'b0, 1'b0, 1'b0);
        else if (pick < 88)
        begin
            // return to some caller
            f = call_chain[$urandom_range(0, call_chain.size() - 1)];
            while (call_chain.size() > 0 && call_chain[call_chain.size() - 1] != f)
                call_chain.delete(call_chain.size() - 1);
            send_record(c, a, 1'b1, f, 1'($urandom), 1'b0, 1'b0);
        end
        else
            send_record(c, a, 1'b1, 16'($urandom), 1'($urandom), 1'($urandom),
                        1'($urandom));
        if (call_chain.size() > 40)
            call_chain.delete();
    endtask

    initial
    begin
        rst_n = 1'b0;
        rec_valid = 1'b0;
        rec = '0;
        rec_sent = 0;
        quiet_tail = 1'b0;
        cyc_now = 64'd100;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: userspace, push, extend, asm swap, unwind, warning, extremes
        send_record(64'd0, '0, 1'b0, 16'd0, 1'b0, 1'b0, 1'b0);
        send_record(64'd5, '0, 1'b0, 16'd7, 1'b1, 1'b1, 1'b1);
        send_record(64'd10, '1, 1'b1, 16'hFFFF, 1'b0, 1'b1, 1'b0);
        send_record(64'd11, '1, 1'b1, 16'hFFFF, 1'b0, 1'b0, 1'b0);
        send_record(64'd12, 40'h1, 1'b1, 16'd0, 1'b0, 1'b1, 1'b1);
        send_record(64'd13, 40'h2, 1'b1, 16'd3, 1'b0, 1'b1, 1'b1);
        send_record(64'd14, 40'h3, 1'b1, 16'd4, 1'b1, 1'b1, 1'b0);
        send_record(64'd15, 40'h4, 1'b1, 16'd5, 1'b0, 1'b1, 1'b0);
        send_record(64'd16, 40'h5, 1'b1, 16'hFFFF, 1'b1, 1'b0, 1'b0);
        send_record(64'd17, 40'hAB_CDEF_0123, 1'b1, 16'h1234, 1'b1, 1'b0, 1'b0);
        send_record(64'd18, 40'h6, 1'b1, 16'h1234, 1'b0, 1'b1, 1'b0);
        send_record(64'hFFFF_FFFF_FFFF_FFF0, '1, 1'b0, '1, 1'b1, 1'b1, 1'b1);
        // fill past the stack limit to hit overflow
        for (int i = 0; i < DEPTH + 2; i++)
            send_record(64'hFFFF_FFFF_FFFF_FFF1 + 64'(i % 14), 40'(i), 1'b1,
                        16'(100 + i), 1'b0, 1'b1, 1'b0);
        // deep unwind to a missing function
        send_record(64'hFFFF_FFFF_FFFF_FFFF, '1, 1'b1, 16'd9, 1'b1, 1'b0, 1'b0);

        // random, with a long receiver hold-off early on
        for (int i = 0; i < 123; i++)
        begin
            if (i == 100)
                quiet_tail = 1'b1;
            random_record();
        end
        rec_valid <= 1'b0;

        while (pending > 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        $display("sent %0d records, checked %0d events", rec_sent, evt_seen);
        $display("covered userspace collapse, asm swaps, unwinds, warnings and overflow");
        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
